// ===== rtl/core/gpe_pkg.sv =====
// Package with shared types and constants for the GPIO port with edge interrupts.
package gpe_pkg;

    localparam int PIN_COUNT = 16;
    localparam int PAIR_W    = 2 * PIN_COUNT;

    localparam logic [15:0] PIN_MASK  = 16'((64'd1 << PIN_COUNT) - 64'd1);
    localparam logic [31:0] PAIR_MASK = 32'((64'd1 << PAIR_W) - 64'd1);

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } gpe_op_t;

    typedef enum logic [3:0] {
        REG_MODE     = 4'd0,
        REG_PULL     = 4'd1,
        REG_INPUT    = 4'd2,
        REG_OUTPUT   = 4'd3,
        REG_SETRESET = 4'd4,
        REG_MASK     = 4'd5,
        REG_RISE     = 4'd6,
        REG_FALL     = 4'd7,
        REG_PENDING  = 4'd8
    } gpe_reg_t;

    localparam logic [1:0] PIN_MODE_OUTPUT = 2'b01;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } gpe_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic [15:0] drive_enable;
        logic        irq;
    } gpe_result_t;

endpackage

// ===== rtl/core/gpe_in_stage.sv =====
// Input register that holds one accepted item until the core consumes it.
module gpe_in_stage
    import gpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  logic      advance,
    input  gpe_item_t item_in,
    output gpe_item_t item,
    output logic      valid
);

    logic      valid_reg;
    logic      valid_next;
    gpe_item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign item  = item_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/core/gpe_core.sv =====
// Port registers, edge detection and the result of one item.
module gpe_core
    import gpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  gpe_item_t   item,
    output gpe_result_t result
);

    logic [31:0] pin_mode_reg,  pin_mode_next;
    logic [31:0] pull_reg,      pull_next;
    logic [15:0] output_reg,    output_next;
    logic [15:0] input_reg,     input_next;
    logic [15:0] mask_reg,      mask_next;
    logic [15:0] rise_reg,      rise_next;
    logic [15:0] fall_reg,      fall_next;
    logic [15:0] pending_reg,   pending_next;

    logic [15:0] wr_lo;
    logic [15:0] wr_hi;
    logic [15:0] now;
    logic [15:0] hit;
    logic [15:0] enables;
    logic [31:0] rd;

    assign wr_lo = item.write_data[15:0] & PIN_MASK;
    assign wr_hi = item.write_data[31:16] & PIN_MASK;
    assign now   = item.pin_levels & PIN_MASK;
    assign hit   = (((now & ~input_reg) & rise_reg) | ((~now & input_reg) & fall_reg))
                   & mask_reg;

    always_comb
    begin
        pin_mode_next = pin_mode_reg;
        pull_next     = pull_reg;
        output_next   = output_reg;
        input_next    = input_reg;
        mask_next     = mask_reg;
        rise_next     = rise_reg;
        fall_next     = fall_reg;
        pending_next  = pending_reg;
        rd            = 32'd0;
        if (fire)
        begin
            case (item.mode)
                OP_READ:
                begin
                    unique case (item.reg_index)
                        REG_MODE:    rd = pin_mode_reg;
                        REG_PULL:    rd = pull_reg;
                        REG_INPUT:   rd = {16'd0, input_reg};
                        REG_OUTPUT:  rd = {16'd0, output_reg};
                        REG_MASK:    rd = {16'd0, mask_reg};
                        REG_RISE:    rd = {16'd0, rise_reg};
                        REG_FALL:    rd = {16'd0, fall_reg};
                        REG_PENDING: rd = {16'd0, pending_reg};
                        default:     rd = 32'd0;
                    endcase
                end
                OP_WRITE:
                begin
                    unique case (item.reg_index)
                        REG_MODE:     pin_mode_next = item.write_data & PAIR_MASK;
                        REG_PULL:     pull_next     = item.write_data & PAIR_MASK;
                        REG_OUTPUT:   output_next   = wr_lo;
                        REG_SETRESET: output_next   = ((output_reg & ~wr_hi) | wr_lo) & PIN_MASK;
                        REG_MASK:     mask_next     = wr_lo;
                        REG_RISE:     rise_next     = wr_lo;
                        REG_FALL:     fall_next     = wr_lo;
                        REG_PENDING:  pending_next  = pending_reg & ~wr_lo;
                        default:      pin_mode_next = pin_mode_reg;
                    endcase
                end
                OP_TICK:
                begin
                    pending_next = (pending_reg | hit) & PIN_MASK;
                    input_next   = now;
                end
                default:
                begin
                    rd = 32'd0;
                end
            endcase
        end
    end

    // A pin is driven only when its mode pair selects output.
    always_comb
    begin
        enables = 16'd0;
        for (int p = 0; p < PIN_COUNT; p++)
        begin
            enables[p] = (pin_mode_next[2*p +: 2] == PIN_MODE_OUTPUT);
        end
    end

    assign result.read_data    = rd;
    assign result.drive_enable = enables;
    assign result.pin_drive    = output_next & enables;
    assign result.irq          = |(pending_next & mask_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_mode_reg <= 32'd0;
            pull_reg     <= 32'd0;
            output_reg   <= 16'd0;
            input_reg    <= 16'd0;
            mask_reg     <= 16'd0;
            rise_reg     <= 16'd0;
            fall_reg     <= 16'd0;
            pending_reg  <= 16'd0;
        end
        else
        begin
            pin_mode_reg <= pin_mode_next;
            pull_reg     <= pull_next;
            output_reg   <= output_next;
            input_reg    <= input_next;
            mask_reg     <= mask_next;
            rise_reg     <= rise_next;
            fall_reg     <= fall_next;
            pending_reg  <= pending_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_read_keeps_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.mode == OP_READ |=> $stable(pending_reg))
        else $error("bus read changed the pending bits");

    a_write_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.mode == OP_WRITE |=> $stable(input_reg))
        else $error("bus write changed the input latch");

    a_tick_keeps_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.mode == OP_TICK |=> $stable(output_reg))
        else $error("sample tick changed the output latch");

    a_write_sets_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.mode == OP_WRITE |=> (pending_reg & ~$past(pending_reg)) == 16'd0)
        else $error("bus write set a pending bit");
`endif

endmodule

// ===== rtl/core/gpe_out_stage.sv =====
// Result register that holds one result item until the receiver takes it.
module gpe_out_stage
    import gpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        taken,
    input  gpe_result_t result_in,
    output gpe_result_t result,
    output logic        valid
);

    logic        valid_reg;
    logic        valid_next;
    gpe_result_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign result = result_reg;
    assign valid  = valid_reg;

endmodule

// ===== rtl/core/gpio_port_edge_interrupt.sv =====
// Top level of the 16-pin GPIO port with its edge interrupt controller.
//
// Every input item is a bus read, a bus write or a pin sample tick, chosen by
// s_tuser; every item produces exactly one result item on the master side,
// carrying the read data, the pin drive, the drive enables and the interrupt.
// An accepted item waits in the input register until the result register is
// free or being emptied, is then executed against the port registers, and
// its result is registered and offered on m_tvalid in the following cycle.
// The block sustains one item per clock while m_tready stays high. The only
// loop is the port register update, done combinationally between the input
// and result registers, so back-to-back items see each other's effects.
// When the receiver stalls, the result register holds its item; the input
// register can still take one more item, after which s_tready drops until
// the result is taken. Nothing is lost or repeated under any stall pattern.
// Reset clears all port registers to zero: all pins are inputs, all lines
// masked, no pending interrupts, and both stage registers are empty.
module gpio_port_edge_interrupt
    import gpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // reg_index [3:0], write_data [35:4], pin_levels [51:36], zero [55:52]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode [1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_data [31:0], pin_drive [47:32], drive_enable [63:48], irq [64],
    // zero [71:65]
    output logic [M_TDATA_W-1:0] m_tdata
);

    gpe_item_t   item_in;
    gpe_item_t   item;
    gpe_result_t result_next;
    gpe_result_t result;
    logic        in_valid;
    logic        load;
    logic        advance;

    // Unpack the slave-side item.
    assign item_in.mode       = s_tuser;
    assign item_in.reg_index  = s_tdata[3:0];
    assign item_in.write_data = s_tdata[35:4];
    assign item_in.pin_levels = s_tdata[51:36];

    // The held item executes when the result register is free or being emptied.
    assign advance  = in_valid && (!m_tvalid || m_tready);
    assign s_tready = !in_valid || advance;
    assign load     = s_tvalid && s_tready;

    gpe_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .advance (advance),
        .item_in (item_in),
        .item    (item),
        .valid   (in_valid)
    );

    gpe_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .result (result_next)
    );

    gpe_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .taken     (m_tready),
        .result_in (result_next),
        .result    (result),
        .valid     (m_tvalid)
    );

    // Pack the master-side item.
    assign m_tdata = {7'd0, result.irq, result.drive_enable, result.pin_drive,
                      result.read_data};

endmodule
